FILE: rtl/utf8_validating_decoder_core_assert.svh
// Assertion macros for the UTF-8 validating decoder core.
// Included by the decoder top level, which checks its own logic; needs nothing else.
`ifndef UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UTF8VD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTF8VD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/utf8vd_pkg.sv
// Types and constants of the UTF-8 validating decoder.
// No dependencies; used by the interfaces, the decode step and the top level.
package utf8vd_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 20;

   localparam logic [CP_W-1:0]   REPL_CP     = 20'h0FFFD;

   localparam logic [BYTE_W-1:0] CTRL_LIMIT  = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_MIN    = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hF3;
   localparam logic [BYTE_W-1:0] CONT_MIN    = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MIN_E0 = 8'hA0;
   localparam logic [BYTE_W-1:0] CONT_MIN_F0 = 8'h90;
   localparam logic [BYTE_W-1:0] CONT_MAX    = 8'hBF;

   typedef struct packed {
      logic [1:0]        bytes_remaining;
      logic [BYTE_W-1:0] lead_byte;
      logic [CP_W-1:0]   group_accum;
      logic              group_ok;
      logic [1:0]        byte_position;
   } utf8vd_state_type;

   typedef struct packed {
      logic            emit;
      logic [CP_W-1:0] code_point;
      logic            was_replaced;
      logic            last_of_string;
   } utf8vd_result_type;

   localparam utf8vd_state_type STATE_CLEAR = '0;

endpackage

FILE: rtl/utf8vd_req_if.sv
// Input channel of the UTF-8 decoder: one byte per beat plus end-of-string flag.
// Depends on utf8vd_pkg for field widths.
interface utf8vd_req_if;
   import utf8vd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;
   logic              end_of_string;

   modport source (output valid, output byte_in, output end_of_string, input ready);
   modport sink   (input valid, input byte_in, input end_of_string, output ready);

endinterface

FILE: rtl/utf8vd_rsp_if.sv
// Result channel of the UTF-8 decoder: one code point per beat.
// Depends on utf8vd_pkg for field widths.
interface utf8vd_rsp_if;
   import utf8vd_pkg::*;

   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            was_replaced;
   logic            last_of_string;

   modport source (output valid, output code_point, output was_replaced,
                   output last_of_string, input ready);
   modport sink   (input valid, input code_point, input was_replaced,
                   input last_of_string, output ready);

endinterface

FILE: rtl/utf8vd_step.sv
// Combinational decode step: current group state and one byte in,
// next group state and an optional result out. Depends on utf8vd_pkg.
module utf8vd_step (
   input  utf8vd_pkg::utf8vd_state_type  cur_state,
   input  logic [7:0]                    byte_in,
   input  logic                          end_of_string,
   output utf8vd_pkg::utf8vd_state_type  nxt_state,
   output utf8vd_pkg::utf8vd_result_type result
);
   import utf8vd_pkg::*;

   logic              ascii_ok;
   logic [BYTE_W-1:0] cont_lo;
   logic              cont_ok;
   logic [CP_W-1:0]   accum_shift;
   logic [1:0]        remaining_dec;

   always_comb begin
      ascii_ok = (byte_in == CHAR_TAB) || (byte_in == CHAR_LF) ||
                 (byte_in == CHAR_CR) || (byte_in >= CTRL_LIMIT);

      // second byte after E0 or F0 has a raised floor to reject overlongs
      cont_lo = CONT_MIN;
      if (cur_state.byte_position == 2'd1) begin
         if (cur_state.lead_byte == LEAD4_MIN) begin
            cont_lo = CONT_MIN_F0;
         end else if (cur_state.lead_byte == LEAD3_MIN) begin
            cont_lo = CONT_MIN_E0;
         end
      end
      cont_ok       = (byte_in >= cont_lo) && (byte_in <= CONT_MAX);
      accum_shift   = {cur_state.group_accum[CP_W-7:0], byte_in[5:0]};
      remaining_dec = cur_state.bytes_remaining - 2'd1;

      nxt_state             = cur_state;
      result.emit           = 1'b0;
      result.code_point     = REPL_CP;
      result.was_replaced   = 1'b1;
      result.last_of_string = end_of_string;

      if (cur_state.bytes_remaining == 2'd0) begin
         if (byte_in < ASCII_LIMIT) begin
            result.emit         = 1'b1;
            result.code_point   = ascii_ok ? {12'd0, byte_in} : REPL_CP;
            result.was_replaced = !ascii_ok;
            if (end_of_string) begin
               nxt_state = STATE_CLEAR;
            end
         end else if (byte_in < LEAD_MIN) begin
            // bare continuation byte
            result.emit = 1'b1;
            if (end_of_string) begin
               nxt_state = STATE_CLEAR;
            end
         end else begin
            nxt_state.lead_byte     = byte_in;
            nxt_state.byte_position = 2'd1;
            if (byte_in >= LEAD4_MIN) begin
               nxt_state.bytes_remaining = 2'd3;
               nxt_state.group_ok        = (byte_in <= LEAD4_MAX);
               nxt_state.group_accum     = {16'd0, byte_in[3:0]};
            end else if (byte_in >= LEAD3_MIN) begin
               nxt_state.bytes_remaining = 2'd2;
               nxt_state.group_ok        = 1'b1;
               nxt_state.group_accum     = {15'd0, byte_in[4:0]};
            end else begin
               nxt_state.bytes_remaining = 2'd1;
               nxt_state.group_ok        = (byte_in >= LEAD2_MIN);
               nxt_state.group_accum     = {14'd0, byte_in[5:0]};
            end
            // lead byte at end of string: group cut short
            if (end_of_string) begin
               nxt_state   = STATE_CLEAR;
               result.emit = 1'b1;
            end
         end
      end else begin
         nxt_state.group_ok        = cur_state.group_ok && cont_ok;
         nxt_state.group_accum     = accum_shift;
         nxt_state.bytes_remaining = remaining_dec;
         nxt_state.byte_position   = cur_state.byte_position + 2'd1;
         if (remaining_dec == 2'd0) begin
            result.emit         = 1'b1;
            result.code_point   = nxt_state.group_ok ? accum_shift : REPL_CP;
            result.was_replaced = !nxt_state.group_ok;
            nxt_state           = STATE_CLEAR;
         end else if (end_of_string) begin
            result.emit = 1'b1;
            nxt_state   = STATE_CLEAR;
         end
      end
   end

endmodule

FILE: rtl/utf8_validating_decoder_core.sv
// UTF-8 validating decoder, top level: input register, group state, result register.
// Depends on utf8vd_pkg, utf8vd_req_if, utf8vd_rsp_if, utf8vd_step and the assert header.
//
// Usage:
//   req_ch carries one raw UTF-8 byte per beat with end_of_string set on the
//   final byte of a string. rsp_ch carries one code point per finished group
//   (single byte, or lead plus its continuation bytes); bytes inside a group
//   give no beat. Errors give U+FFFD with was_replaced set; last_of_string
//   marks the beat caused by the final byte, which also closes any open group.
//   Path: an accepted byte passes the input register, then the result register,
//   before its beat can show on rsp_ch.valid; a held-off rsp_ch can keep it in
//   the input register.
//   Throughput: one byte per cycle while rsp_ch is not held off; the decode step
//   is a single compare-and-shift pass between the input and result registers.
//   Stall: while rsp_ch is held off, the result register holds its beat and
//   the input register takes one more byte if it is empty, then req_ch.ready drops.
//   Reset: synchronous, active high; empties both registers and closes any
//   open group, so the next byte starts a new string.
`include "utf8_validating_decoder_core_assert.svh"

module utf8_validating_decoder_core (
   input  logic          clock,
   input  logic          reset,
   utf8vd_req_if.sink    req_ch,
   utf8vd_rsp_if.source  rsp_ch
);
   import utf8vd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eos_ff;
   utf8vd_state_type  state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]   rsp_cp_ff;
   logic              rsp_repl_ff;
   logic              rsp_last_ff;

   utf8vd_state_type  step_state;
   utf8vd_result_type step_result;
   logic              out_free;
   logic              step_fire;
   logic              req_take;

   logic              rsp_repl_beat;
   logic              rsp_cp_repl;
   logic              rsp_ctrl_beat;
   logic              rsp_ws_cp;
   logic              eos_step;
   logic              group_idle;
   logic              group_open;
   logic              lead_seen;

   utf8vd_step u_step (
      .cur_state     (state_ff),
      .byte_in       (in_byte_ff),
      .end_of_string (in_eos_ff),
      .nxt_state     (step_state),
      .result        (step_result)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ch.ready;
      step_fire    = in_valid_ff && out_free;
      req_take     = req_ch.valid && req_ch.ready;
      in_valid_in  = req_take || (in_valid_ff && !step_fire);
      state_in     = step_fire ? step_state : state_ff;
      // hold the result beat until taken, replace it when the next one lands
      rsp_valid_in = step_fire ? step_result.emit : (rsp_valid_ff && !rsp_ch.ready);
   end

   assign req_ch.ready          = !in_valid_ff || step_fire;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.code_point     = rsp_cp_ff;
   assign rsp_ch.was_replaced   = rsp_repl_ff;
   assign rsp_ch.last_of_string = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_ch.byte_in;
         in_eos_ff  <= req_ch.end_of_string;
      end
      if (step_fire && step_result.emit) begin
         rsp_cp_ff   <= step_result.code_point;
         rsp_repl_ff <= step_result.was_replaced;
         rsp_last_ff <= step_result.last_of_string;
      end
   end

   always_comb begin
      rsp_repl_beat = rsp_valid_ff && rsp_repl_ff;
      rsp_cp_repl   = (rsp_cp_ff == REPL_CP);
      rsp_ctrl_beat = rsp_valid_ff && !rsp_repl_ff && (rsp_cp_ff < {12'd0, CTRL_LIMIT});
      rsp_ws_cp     = (rsp_cp_ff == {12'd0, CHAR_TAB}) || (rsp_cp_ff == {12'd0, CHAR_LF}) ||
                      (rsp_cp_ff == {12'd0, CHAR_CR});
      eos_step      = step_fire && in_eos_ff;
      group_idle    = (state_ff.bytes_remaining == 2'd0) && (state_ff.byte_position == 2'd0);
      group_open    = (state_ff.bytes_remaining != 2'd0);
      lead_seen     = (state_ff.lead_byte >= LEAD_MIN);
   end

   `UTF8VD_ASSERT_IMP(a_repl_value, clock, reset, rsp_repl_beat, rsp_cp_repl, "bad replacement")
   `UTF8VD_ASSERT_IMP(a_no_ctrl_pass, clock, reset, rsp_ctrl_beat, rsp_ws_cp, "control passed")
   `UTF8VD_ASSERT_NXT(a_eos_closes, clock, reset, eos_step, group_idle, "group open after end")
   `UTF8VD_ASSERT_IMP(a_open_has_lead, clock, reset, group_open, lead_seen, "open group, no lead")

endmodule

FILE: dv/utf8_validating_decoder_core_tb.sv
// Testbench for utf8_validating_decoder_core: drives byte beats, predicts code points.
// Depends on utf8vd_pkg, utf8vd_req_if, utf8vd_rsp_if and the decoder RTL.
`timescale 1ns / 1ps

module utf8_validating_decoder_core_tb;
   import utf8vd_pkg::*;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          PHASE_ITEMS  = 433;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
   localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
   localparam logic [7:0]  BYTE_MAX     = 8'hFF;

   typedef struct {
      logic [CP_W-1:0] code_point;
      logic            was_replaced;
      logic            last_of_string;
   } cp_beat_type;

   class code_point_board;
      cp_beat_type     pending_cps[$];
      int unsigned     mismatches;
      bit [1:0]        cont_left;
      bit [7:0]        lead;
      bit [CP_W-1:0]   accum;
      bit              group_ok;
      bit [1:0]        pos;

      function void close_group();
         cont_left = '0;
         lead      = '0;
         accum     = '0;
         group_ok  = 1'b0;
         pos       = '0;
      endfunction

      function void push_cp(bit [CP_W-1:0] cp, bit repl, bit last);
         cp_beat_type beat;
         beat.code_point     = cp;
         beat.was_replaced   = repl;
         beat.last_of_string = last;
         pending_cps.insert(pending_cps.size(), beat);
      endfunction

      function void note_byte(bit [7:0] b, bit eos);
         bit         ok;
         bit [7:0]   lo;
         if (cont_left == 0) begin
            if (b < ASCII_LIMIT) begin
               ok = (b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR || b >= CTRL_LIMIT);
               push_cp(ok ? {{(CP_W-8){1'b0}}, b} : REPL_CP, !ok, eos);
               if (eos) close_group();
            end else if (b < LEAD_MIN) begin
               push_cp(REPL_CP, 1'b1, eos);
               if (eos) close_group();
            end else begin
               lead = b;
               pos  = 2'd1;
               if (b >= LEAD4_MIN) begin
                  cont_left = 2'd3;
                  group_ok  = (b <= LEAD4_MAX);
                  accum     = {{(CP_W-4){1'b0}}, b[3:0]};
               end else if (b >= LEAD3_MIN) begin
                  cont_left = 2'd2;
                  group_ok  = 1'b1;
                  accum     = {{(CP_W-5){1'b0}}, b[4:0]};
               end else begin
                  cont_left = 2'd1;
                  group_ok  = (b >= LEAD2_MIN);
                  accum     = {{(CP_W-6){1'b0}}, b[5:0]};
               end
               // a lead that ends the string leaves the group cut short
               if (eos) begin
                  close_group();
                  push_cp(REPL_CP, 1'b1, 1'b1);
               end
            end
         end else begin
            lo = CONT_MIN;
            if (pos == 2'd1) begin
               if (lead == LEAD4_MIN) lo = CONT_MIN_F0;
               else if (lead == LEAD3_MIN) lo = CONT_MIN_E0;
            end
            if (b < lo || b > CONT_MAX) group_ok = 1'b0;
            accum     = {accum[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            pos       = pos + 2'd1;
            if (cont_left == 0) begin
               push_cp(group_ok ? accum : REPL_CP, !group_ok, eos);
               close_group();
            end else if (eos) begin
               close_group();
               push_cp(REPL_CP, 1'b1, 1'b1);
            end
         end
      endfunction

      function void check_result(logic [CP_W-1:0] cp, logic repl, logic last);
         cp_beat_type exp_beat;
         if (pending_cps.size() == 0) begin
            $error("unexpected result beat: code_point %h", cp);
            mismatches++;
            return;
         end
         exp_beat = pending_cps.pop_front();
         if (cp !== exp_beat.code_point) begin
            $error("code_point: expected %h, actual %h", exp_beat.code_point, cp);
            mismatches++;
         end
         if (repl !== exp_beat.was_replaced) begin
            $error("was_replaced: expected %b, actual %b", exp_beat.was_replaced, repl);
            mismatches++;
         end
         if (last !== exp_beat.last_of_string) begin
            $error("last_of_string: expected %b, actual %b", exp_beat.last_of_string, last);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_cps.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   utf8vd_req_if req_ch ();
   utf8vd_rsp_if rsp_ch ();

   utf8_validating_decoder_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   code_point_board board = new();
   int              send_idle_pct = 22;
   int              recv_idle_pct = 67;
   int              items_sent;

   bit [8:0] directed_beats [23] = '{
      {1'b0, 8'h00}, {1'b0, 8'h09}, {1'b0, 8'h0D}, {1'b0, 8'h1F}, {1'b0, 8'h7F},
      {1'b0, 8'h80},
      {1'b0, 8'hC2}, {1'b0, 8'h80}, {1'b0, 8'hDF}, {1'b0, 8'hBF},
      {1'b0, 8'hC0}, {1'b0, 8'h41},
      {1'b0, 8'hE0}, {1'b0, 8'h9F}, {1'b0, 8'h80},
      {1'b0, 8'hF0}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b0, 8'h80},
      {1'b0, 8'hE1}, {1'b1, 8'h80},
      {1'b1, 8'hC5},
      {1'b1, 8'hFF}
   };

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver stalls at random, one decision per falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.code_point, rsp_ch.was_replaced, rsp_ch.last_of_string);
         if (req_ch.valid && req_ch.ready)
            board.note_byte(req_ch.byte_in, req_ch.end_of_string);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_byte(input bit [7:0] b, input bit eos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.byte_in       <= b;
      req_ch.end_of_string <= eos;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_string(input int n_groups);
      bit [7:0] seq[$];
      int       kind;
      bit [7:0] lead;
      int       n_cont;
      for (int g = 0; g < n_groups; g++) begin
         kind = int'($urandom_range(0, 99));
         if (kind < 25) begin
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 2))
                  0: seq.insert(seq.size(), CHAR_TAB);
                  1: seq.insert(seq.size(), CHAR_LF);
                  default: seq.insert(seq.size(), CHAR_CR);
               endcase
            end else begin
               seq.insert(seq.size(), 8'($urandom_range(CTRL_LIMIT, ASCII_LIMIT - 1)));
            end
         end else if (kind < 40) begin
            seq.insert(seq.size(), 8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
            seq.insert(seq.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
         end else if (kind < 55) begin
            lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
            seq.insert(seq.size(), lead);
            seq.insert(seq.size(), 8'(lead == LEAD3_MIN ? $urandom_range(CONT_MIN_E0, CONT_MAX)
                                                        : $urandom_range(CONT_MIN, CONT_MAX)));
            seq.insert(seq.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
         end else if (kind < 70) begin
            lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
            seq.insert(seq.size(), lead);
            seq.insert(seq.size(), 8'(lead == LEAD4_MIN ? $urandom_range(CONT_MIN_F0, CONT_MAX)
                                                        : $urandom_range(CONT_MIN, CONT_MAX)));
            repeat (2) seq.insert(seq.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
         end else if (kind < 85) begin
            seq.insert(seq.size(), 8'($urandom_range(0, BYTE_MAX)));
         end else begin
            // broken group: any lead, a random number (0 to 3) of mostly continuation bytes
            seq.insert(seq.size(), 8'($urandom_range(LEAD_MIN, BYTE_MAX)));
            n_cont = int'($urandom_range(0, 3));
            repeat (n_cont) begin
               if ($urandom_range(0, 3) == 0)
                  seq.insert(seq.size(), 8'($urandom_range(0, BYTE_MAX)));
               else
                  seq.insert(seq.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
            end
         end
      end
      foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
   endtask

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.byte_in       = '0;
      req_ch.end_of_string = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_beats[i]) send_byte(directed_beats[i][7:0], directed_beats[i][8]);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 22; recv_idle_pct = 67; end
            1: begin send_idle_pct = 67; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         while (items_sent < (phase + 1) * PHASE_ITEMS)
            send_string($urandom_range(1, 10));
      end
      req_ch.valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.outstanding() != 0) begin
         $error("%0d expected code points never arrived", board.outstanding());
         board.mismatches++;
      end

      if (board.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
